// ===== hw/rtl/u8sd_pkg.sv =====
package u8sd_pkg;

	// Value carried by every error result.
	localparam logic [31:0] ERR_VALUE = 32'd1;

	// Byte class masks and patterns.
	localparam logic [7:0] MASK_1 = 8'h80;
	localparam logic [7:0] MASK_2 = 8'hc0;
	localparam logic [7:0] MASK_3 = 8'he0;
	localparam logic [7:0] MASK_4 = 8'hf0;
	localparam logic [7:0] MASK_5 = 8'hf8;
	localparam logic [7:0] MASK_6 = 8'hfc;
	localparam logic [7:0] MASK_7 = 8'hfe;
	localparam logic [7:0] CONT_PATTERN = 8'h80;
	localparam logic [7:0] LEAD_7 = 8'hfe;

	// Most results one byte can cause.
	localparam int unsigned MAX_RESULTS = 7;

	// One input word held in the input register.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	// Result burst for one byte: count words, all errors except the last,
	// which carries last_cp and last_err.
	typedef struct packed {
		logic [2:0]  count;
		logic [31:0] last_cp;
		logic        last_err;
	} burst_t;

endpackage

// ===== hw/rtl/u8sd_in_stage.sv =====
module u8sd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  u8sd_pkg::item_t in_item,
	input  logic           take,
	output logic           valid_s1,
	output u8sd_pkg::item_t item_s1
);
	import u8sd_pkg::*;

	// The register refills in the same cycle its word is taken.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/u8sd_decode.sv =====
module u8sd_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  u8sd_pkg::item_t item_s1,
	input  logic            emit_free,
	output logic            take,
	output logic            load,
	output u8sd_pkg::burst_t burst
);
	import u8sd_pkg::*;

	logic [2:0]  expect_q;
	logic [2:0]  len_q;
	logic [31:0] acc_q;

	logic [2:0]  expect_d;
	logic [2:0]  len_d;
	logic [31:0] acc_d;

	logic [7:0]  b;
	logic        eot;
	logic        is_cont;
	logic        is_ascii;
	logic        is_lead;
	logic [2:0]  lead_len;
	logic [31:0] lead_bits;
	logic [2:0]  taken;
	logic [2:0]  exp_dec;
	logic [31:0] acc_shift;

	assign b   = item_s1.text_byte;
	assign eot = item_s1.end_of_text;

	assign is_cont  = (b & MASK_2) == CONT_PATTERN;
	assign is_ascii = (b & MASK_1) == 8'h00;

	// Lead byte decode: total length and payload bits it carries.
	always_comb begin
		is_lead   = 1'b1;
		lead_len  = 3'd0;
		lead_bits = '0;
		if ((b & MASK_3) == 8'hc0) begin
			lead_len  = 3'd2;
			lead_bits = {27'd0, b[4:0]};
		end else if ((b & MASK_4) == 8'he0) begin
			lead_len  = 3'd3;
			lead_bits = {28'd0, b[3:0]};
		end else if ((b & MASK_5) == 8'hf0) begin
			lead_len  = 3'd4;
			lead_bits = {29'd0, b[2:0]};
		end else if ((b & MASK_6) == 8'hf8) begin
			lead_len  = 3'd5;
			lead_bits = {30'd0, b[1:0]};
		end else if ((b & MASK_7) == 8'hfc) begin
			lead_len  = 3'd6;
			lead_bits = {31'd0, b[0]};
		end else if (b == LEAD_7) begin
			lead_len  = 3'd7;
		end else begin
			is_lead = 1'b0;
		end
	end

	assign taken     = len_q - expect_q;
	assign exp_dec   = expect_q - 3'd1;
	assign acc_shift = {acc_q[25:0], b[5:0]};

	always_comb begin
		expect_d       = expect_q;
		len_d          = len_q;
		acc_d          = acc_q;
		burst.count    = 3'd0;
		burst.last_cp  = ERR_VALUE;
		burst.last_err = 1'b1;
		if (expect_q != 3'd0 && is_cont) begin
			if (exp_dec == 3'd0) begin
				// Sequence complete.
				burst.count    = 3'd1;
				burst.last_cp  = acc_shift;
				burst.last_err = 1'b0;
				expect_d       = 3'd0;
				len_d          = 3'd0;
				acc_d          = '0;
			end else if (eot) begin
				// Flush what has been taken, this byte included.
				burst.count = len_q - exp_dec;
				expect_d    = 3'd0;
				len_d       = 3'd0;
				acc_d       = '0;
			end else begin
				expect_d = exp_dec;
				acc_d    = acc_shift;
			end
		end else begin
			// A broken sequence first gives one error per byte taken,
			// then this byte is decoded fresh.
			burst.count = (expect_q != 3'd0) ? taken : 3'd0;
			expect_d    = 3'd0;
			len_d       = 3'd0;
			acc_d       = '0;
			if (is_ascii) begin
				burst.count    = burst.count + 3'd1;
				burst.last_cp  = {24'd0, b};
				burst.last_err = 1'b0;
			end else if (is_lead && !is_cont) begin
				if (eot) begin
					burst.count = burst.count + 3'd1;
				end else begin
					len_d    = lead_len;
					expect_d = lead_len - 3'd1;
					acc_d    = lead_bits;
				end
			end else begin
				// Lone continuation or 0xFF.
				burst.count = burst.count + 3'd1;
			end
		end
	end

	// A byte with no result never waits for the output side.
	assign take = valid_s1 && (burst.count == 3'd0 || emit_free);
	assign load = take && burst.count != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 3'd0;
			len_q    <= 3'd0;
			acc_q    <= '0;
		end else if (take) begin
			expect_q <= expect_d;
			len_q    <= len_d;
			acc_q    <= acc_d;
		end
	end

endmodule

// ===== hw/rtl/u8sd_emit.sv =====
module u8sd_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  u8sd_pkg::burst_t burst,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      code_point,
	output logic             decode_error,
	output logic             last_of_run
);
	import u8sd_pkg::*;

	logic [2:0]  rem_q;
	logic [31:0] cp_q;
	logic        err_q;

	assign out_valid    = rem_q != 3'd0;
	assign last_of_run  = rem_q == 3'd1;
	assign code_point   = last_of_run ? cp_q : ERR_VALUE;
	assign decode_error = last_of_run ? err_q : 1'b1;

	// Free once the final word of the current burst leaves.
	assign free = (rem_q == 3'd0) || (last_of_run && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= burst.count;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q  <= burst.last_cp;
			err_q <= burst.last_err;
		end
	end

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// Channel   Dir  Word                      Meaning
// s_axis    in   tdata[7:0]  text_byte     one byte of UTF-8 text
//                tlast       end_of_text   final byte, flushes an open sequence
// m_axis    out  tdata[31:0] code_point    decoded value, 1 on an error word
//                tuser       decode_error  malformed byte or sequence
//                tlast       last_of_run   final word caused by one input byte
//
// One input byte is taken per cycle. A byte is decoded from the input
// register into the output burst register, and its first result word is
// presented once that register is loaded, which waits while the previous
// burst drains. A byte that causes n result words (n is 0 to 7) holds the
// output burst register until all n words have left; the input stalls only
// while a burst longer than one word drains or the downstream side holds
// tready low. Lead bytes that open a sequence cause no word and never wait.
// Reset clears the decoder state and empties both registers.
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] code_point
	output logic        m_axis_tuser,   // [0] decode_error
	output logic        m_axis_tlast
);
	import u8sd_pkg::*;

	item_t       in_item;
	item_t       item_s1;
	logic        valid_s1;
	logic        take;
	logic        load;
	logic        emit_free;
	burst_t      burst;
	logic [31:0] code_point;
	logic        decode_error;

	assign in_item.text_byte   = s_axis_tdata;
	assign in_item.end_of_text = s_axis_tlast;

	// Input register.
	u8sd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Decoder state and the per-byte result burst.
	u8sd_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.emit_free (emit_free),
		.take      (take),
		.load      (load),
		.burst     (burst)
	);

	// Output burst register, one word per cycle while tready is high.
	u8sd_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.burst        (burst),
		.free         (emit_free),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.code_point   (code_point),
		.decode_error (decode_error),
		.last_of_run  (m_axis_tlast)
	);

	assign m_axis_tdata = code_point;
	assign m_axis_tuser = decode_error;

	// Every word before the last one of a burst is an error word.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> decode_error && code_point == ERR_VALUE)
	else $error("non-final word of a burst is not an error word");

	// A new burst is only loaded when the previous one has drained or its final word leaves.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> emit_free)
	else $error("burst loaded over undelivered words");

	// A burst always carries at least one word.
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_axis_tvalid)
	else $error("empty burst loaded");

endmodule

// ===== tb/utf8_stream_decoder_tb.sv =====
module utf8_stream_decoder_tb;

	import u8sd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 244;
	localparam int TAIL_ITEMS   = 50;   // final stretch runs with no idling
	localparam int HOLD_AFTER   = 90;   // bytes accepted before the long output stall
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_PRINTED  = 40;

	// Directed bytes as {end_of_text, text_byte}.
	localparam int N_DIRECTED = 26;
	localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
		9'h000, 9'h07f,                                // smallest and largest ASCII
		9'h080, 9'h0ff, 9'h0bf,                        // lone continuations and 0xFF
		9'h0c3, 9'h0a9,                                // two-byte form
		9'h0fe, 9'h0bf, 9'h0bf, 9'h0bf, 9'h0bf, 9'h0bf, 9'h0bf, // seven-byte form, truncated
		9'h0e2, 9'h041,                                // sequence broken by ASCII
		9'h0fe, 9'h080, 9'h080, 9'h080, 9'h080, 9'h080, 9'h0ff, // longest error burst
		9'h0e2, 9'h182,                                // end of text inside a sequence
		9'h1c3                                         // end of text on a lone lead
	};

	typedef struct {
		logic [31:0] code_point;
		logic        decode_error;
		logic        last_of_run;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	item_t pending[$];          // bytes still to be offered
	word_t expected_words[$];   // decoded words not yet seen on the output
	word_t burst_words[$];      // words caused by the byte being predicted

	// Decoder state as predicted.
	logic [2:0]  open_remaining = 3'd0;
	logic [2:0]  open_length = 3'd0;
	logic [31:0] open_value = 32'd0;

	int items_total = 0;
	int items_accepted = 0;
	int words_seen = 0;
	int error_words = 0;
	int longest_burst = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	utf8_stream_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// ---------------------------------------------------------------- decoder prediction

	task automatic push_word(input logic [31:0] cp, input logic err);
		word_t w;
		if (burst_words.size() < MAX_RESULTS) begin
			w.code_point = cp;
			w.decode_error = err;
			w.last_of_run = 1'b0;
			burst_words.push_back(w);
		end
	endtask

	// One error per byte already taken into the open sequence, then back to idle.
	task automatic drop_open_sequence();
		logic [2:0] taken;
		taken = open_length - open_remaining;
		for (int i = 0; i < taken; i++)
			push_word(ERR_VALUE, 1'b1);
		open_remaining = 3'd0;
		open_length = 3'd0;
		open_value = 32'd0;
	endtask

	task automatic open_sequence(input logic [2:0] len, input logic [31:0] bits);
		open_length = len;
		open_remaining = len - 3'd1;
		open_value = bits;
	endtask

	task automatic start_fresh(input logic [7:0] b);
		if ((b & MASK_1) == 8'h00)
			push_word({24'd0, b}, 1'b0);
		else if ((b & MASK_2) == CONT_PATTERN)
			push_word(ERR_VALUE, 1'b1);
		else if ((b & MASK_3) == MASK_2)
			open_sequence(3'd2, {27'd0, b[4:0]});
		else if ((b & MASK_4) == MASK_3)
			open_sequence(3'd3, {28'd0, b[3:0]});
		else if ((b & MASK_5) == MASK_4)
			open_sequence(3'd4, {29'd0, b[2:0]});
		else if ((b & MASK_6) == MASK_5)
			open_sequence(3'd5, {30'd0, b[1:0]});
		else if ((b & MASK_7) == MASK_6)
			open_sequence(3'd6, {31'd0, b[0]});
		else if (b == LEAD_7)
			open_sequence(3'd7, 32'd0);
		else
			push_word(ERR_VALUE, 1'b1);
	endtask

	task automatic predict_byte(input item_t it);
		burst_words = {};
		if (open_remaining != 3'd0) begin
			if ((it.text_byte & MASK_2) == CONT_PATTERN) begin
				// Six payload bits per continuation; the seven-byte form overflows 32 bits.
				open_value = {open_value[25:0], it.text_byte[5:0]};
				open_remaining = open_remaining - 3'd1;
				if (open_remaining == 3'd0) begin
					push_word(open_value, 1'b0);
					open_length = 3'd0;
					open_value = 32'd0;
				end
			end else begin
				drop_open_sequence();
				start_fresh(it.text_byte);
			end
		end else begin
			start_fresh(it.text_byte);
		end
		if (it.end_of_text && open_remaining != 3'd0)
			drop_open_sequence();
		if (burst_words.size() != 0) begin
			burst_words[burst_words.size() - 1].last_of_run = 1'b1;
			if (burst_words.size() > longest_burst)
				longest_burst = burst_words.size();
			foreach (burst_words[i])
				expected_words.push_back(burst_words[i]);
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic add_byte(input logic [7:0] b, input logic eot);
		item_t it;
		it.text_byte = b;
		it.end_of_text = eot;
		pending.push_back(it);
	endtask

	function automatic logic random_eot();
		return $urandom_range(0, 19) == 0;
	endfunction

	// A lead byte of the given length with random payload, then random
	// continuations; a cut sequence stops early so the next byte breaks it.
	task automatic add_sequence(input int len, input logic cut);
		logic [7:0] ones;
		logic [7:0] lead;
		int conts;
		ones = 8'hff;
		if (len == 1)
			lead = 8'($urandom_range(0, 127));
		else
			lead = ~(ones >> len) | (8'($urandom) & (ones >> (len + 1)));
		add_byte(lead, random_eot());
		conts = cut ? $urandom_range(0, len - 2) : len - 1;
		for (int i = 0; i < conts; i++)
			add_byte(CONT_PATTERN | (8'($urandom) & 8'h3f), random_eot());
	endtask

	initial begin
		int pick;
		foreach (DIRECTED[i])
			add_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		while (pending.size() < N_DIRECTED + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				add_sequence($urandom_range(1, 7), 1'b0);
			else if (pick < 9)
				add_sequence($urandom_range(2, 7), 1'b1);
			else
				add_byte(8'($urandom), random_eot());
		end
		pending[pending.size() - 1].end_of_text = 1'b1;
		items_total = pending.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || expected_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
		$display("Summary: %0d bytes decoded into %0d words, %0d of them error words.",
			items_accepted, words_seen, error_words);
		$display("Summary: longest burst %0d words; output held off for %0d cycles once.",
			longest_burst, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// ---------------------------------------------------------------- byte driver

	always @(posedge clk) begin : byte_driver
		logic offered;
		logic next_valid;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			offered = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				void'(pending.pop_front());
				offered = 1'b0;
			end
			if (offered) begin
				next_valid = 1'b1;   // a word once offered stays until taken
			end else if (send_gap != 0) begin
				send_gap--;
				next_valid = 1'b0;
			end else if (pending.size() > TAIL_ITEMS && $urandom_range(0, 6) == 0) begin
				send_gap = $urandom_range(0, 8);
				next_valid = 1'b0;
			end else begin
				next_valid = pending.size() != 0;
			end
			s_axis_tvalid <= next_valid;
			if (next_valid) begin
				s_axis_tdata <= pending[0].text_byte;
				s_axis_tlast <= pending[0].end_of_text;
			end
		end
	end

	// ---------------------------------------------------------------- output side

	// One long stall of the output while the driver keeps offering bytes.
	always @(posedge clk) begin : output_hold
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin : ready_gen
		logic next_ready;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_left != 0) begin
				next_ready = 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				next_ready = 1'b0;
			end else if (items_accepted + TAIL_ITEMS < items_total &&
					$urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 8);
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			m_axis_tready <= next_ready;
		end
	end

	// Checks each output word against the oldest prediction, then predicts
	// for the byte taken at this edge; both in one process keeps the order fixed.
	always @(posedge clk) begin : word_monitor
		word_t want;
		item_t taken;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_seen <= words_seen + 1;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end else begin
					want = expected_words.pop_front();
					if (want.decode_error)
						error_words++;
					if (m_axis_tdata !== want.code_point)
						report_mismatch($sformatf("code_point %h, expected %h",
							m_axis_tdata, want.code_point));
					if (m_axis_tuser !== want.decode_error)
						report_mismatch($sformatf("decode_error %b, expected %b",
							m_axis_tuser, want.decode_error));
					if (m_axis_tlast !== want.last_of_run)
						report_mismatch($sformatf("last_of_run %b, expected %b",
							m_axis_tlast, want.last_of_run));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				taken.text_byte = s_axis_tdata;
				taken.end_of_text = s_axis_tlast;
				predict_byte(taken);
				items_accepted <= items_accepted + 1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected.",
				cycle_count, expected_words.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
